>>> rtl/core/ookpb_pkg.sv
// Shared types and constants for the OOK pulse-pair bit decoder.
// No dependencies; imported by every module of the block.
package ookpb_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_TIME   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_TIME    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FIXED_TOL    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TOL_PERCENT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BITS_NEEDED  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PREAMBLE     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PPM_SELECT   = 3'd6;

  // Reset values of the configuration registers
  localparam logic [15:0] RstShortTime = 16'd400;
  localparam logic [15:0] RstLongTime  = 16'd800;
  localparam logic [15:0] RstFixedTol  = 16'd0;
  localparam logic [6:0]  RstTolPct    = 7'd20;
  localparam logic [6:0]  RstBitsNeed  = 7'd24;
  localparam logic [7:0]  RstPreamble  = 8'd0;
  localparam logic        RstPpmSel    = 1'b0;

  // Derived tolerance width: short_time * percent / 100 fits 17 bits
  localparam int unsigned TolW = 17;
  localparam logic [22:0] RstTolProd = 23'(400 * 20);
  localparam logic [TolW-1:0] RstTol = 17'(400 * 20 / 100);

  // Reciprocal of 100 scaled by 2^32 (rounded up); exact for 23-bit dividends
  localparam logic [25:0] Recip100 = 26'd42949673;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] short_time;
    logic [15:0] long_time;
    logic [15:0] fixed_tol;
    logic [6:0]  tol_pct;
    logic [6:0]  bits_needed;
    logic [7:0]  preamble;
    logic        ppm_sel;
  } cfg_t;

  // One pulse item
  typedef struct packed {
    logic [15:0] duration;
    logic        capture_start;
    logic        capture_end;
  } pulse_t;

endpackage

>>> rtl/core/ook_pulse_pair_bit_decoder.sv
// OOK pulse-pair bit decoder, top level: config registers, input and result registers.
// Depends on ookpb_pkg, ookpb_tol, ookpb_dec.
//
// Usage:
//   Pulses enter on the in_* channel (valid/stall), one duration per transaction,
//   alternating high and low, with capture_start on the first pulse of a capture
//   and capture_end on its last. At most one result per capture leaves on the
//   out_* channel: found=1 once bits_needed bits are in, found=0 on an invalid
//   pair or at capture end, with the partial bits.
//   Path: a pulse waits in the input register, and its result is registered
//   into the result register by one registered decision pass when it fires.
//   Throughput: one pulse per cycle unless a tolerance recompute or a stalled result holds it.
//   Configuration: writes on cfg_* (valid/ready, always ready) while idle. Each
//   write restarts the two-stage tolerance multiply, which holds decoding until it
//   completes; pulses are still captured into the input register meanwhile.
//   Reset loads the register defaults and clears the decoder state.
//   When out_stall_i holds a pending result, the pulse in the input register
//   waits and in_stall_o rises; a pulse that gives no result also waits then.
module ook_pulse_pair_bit_decoder
  import ookpb_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  // pulse input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           duration_i,
  input  logic                  capture_start_i,
  input  logic                  capture_end_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] frame_bits_o,
  output logic [6:0]            bit_total_o,
  output logic                  found_o
);

  cfg_t   cfg_q, cfg_d;
  logic   cfg_we;
  logic   in_valid_q;
  pulse_t pulse_q;
  logic   fire;
  logic   accept;

  logic [TolW-1:0]       tol;
  logic                  tol_ready;
  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_bits;
  logic [6:0]            res_total;
  logic                  res_found;

  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] frame_bits_q;
  logic [6:0]            bit_total_q;
  logic                  found_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_SHORT_TIME:  cfg_d.short_time  = cfg_data_i;
        CFG_LONG_TIME:   cfg_d.long_time   = cfg_data_i;
        CFG_FIXED_TOL:   cfg_d.fixed_tol   = cfg_data_i;
        CFG_TOL_PERCENT: cfg_d.tol_pct     = cfg_data_i[6:0];
        CFG_BITS_NEEDED: cfg_d.bits_needed = cfg_data_i[6:0];
        CFG_PREAMBLE:    cfg_d.preamble    = cfg_data_i[7:0];
        CFG_PPM_SELECT:  cfg_d.ppm_sel     = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_time  <= RstShortTime;
      cfg_q.long_time   <= RstLongTime;
      cfg_q.fixed_tol   <= RstFixedTol;
      cfg_q.tol_pct     <= RstTolPct;
      cfg_q.bits_needed <= RstBitsNeed;
      cfg_q.preamble    <= RstPreamble;
      cfg_q.ppm_sel     <= RstPpmSel;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ookpb_tol u_tol (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cfg_we_i (cfg_we),
    .tol_o    (tol),
    .ready_o  (tol_ready)
  );

  // Handshake: a held pulse fires when tol is ready and the result register can take it
  assign fire       = in_valid_q & tol_ready & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~fire;
  assign accept     = in_valid_i & ~in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pulse_q.duration      <= duration_i;
      pulse_q.capture_start <= capture_start_i;
      pulse_q.capture_end   <= capture_end_i;
    end
  end

  ookpb_dec #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tol_i       (tol),
    .fire_i      (fire),
    .pulse_i     (pulse_q),
    .res_valid_o (res_valid),
    .res_bits_o  (res_bits),
    .res_total_o (res_total),
    .res_found_o (res_found)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      frame_bits_q <= res_bits;
      bit_total_q  <= res_total;
      found_q      <= res_found;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_bits_o = frame_bits_q;
  assign bit_total_o  = bit_total_q;
  assign found_o      = found_q;

endmodule

>>> rtl/core/ookpb_tol.sv
// Tolerance unit: two-stage registered short_time * percent / 100, or the fixed value.
// Depends on ookpb_pkg.
module ookpb_tol
  import ookpb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            cfg_we_i,
  output logic [TolW-1:0] tol_o,
  output logic            ready_o
);

  logic [22:0]     prod_q;
  logic [48:0]     quot_full;
  logic [TolW-1:0] tol_d, tol_q;
  logic [1:0]      busy_d, busy_q;

  // Divide by 100 through the scaled reciprocal
  assign quot_full = 49'(prod_q) * 49'(Recip100);

  always_comb begin
    if (cfg_i.fixed_tol != 16'd0) begin
      tol_d = {1'b0, cfg_i.fixed_tol};
    end else begin
      tol_d = quot_full[48:32];
    end
  end

  // Any config write restarts the recompute, holding ready_o low until it is done
  always_comb begin
    if (cfg_we_i) begin
      busy_d = 2'd2;
    end else if (busy_q != 2'd0) begin
      busy_d = busy_q - 2'd1;
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= RstTolProd;
      tol_q  <= RstTol;
      busy_q <= 2'd0;
    end else begin
      prod_q <= 23'(cfg_i.short_time) * 23'(cfg_i.tol_pct);
      tol_q  <= tol_d;
      busy_q <= busy_d;
    end
  end

  assign tol_o   = tol_q;
  assign ready_o = (busy_q == 2'd0);

endmodule

>>> rtl/core/ookpb_dec.sv
// Pulse-pair decode stage: decoder state registers and the per-pulse decision.
// Depends on ookpb_pkg.
module ookpb_dec
  import ookpb_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic [TolW-1:0]       tol_i,
  input  logic                  fire_i,
  input  pulse_t                pulse_i,
  output logic                  res_valid_o,
  output logic [DATA_WIDTH-1:0] res_bits_o,
  output logic [6:0]            res_total_o,
  output logic                  res_found_o
);

  localparam logic [6:0] DwCnt = 7'(DATA_WIDTH);

  function automatic logic [16:0] abs_diff(logic [16:0] a, logic [16:0] b);
    if (a > b) begin
      return a - b;
    end
    return b - a;
  endfunction

  logic [7:0]            pos_d, pos_q;
  logic                  phase_d, phase_q;
  logic [15:0]           held_d, held_q;
  logic [DATA_WIDTH-1:0] shift_d, shift_q;
  logic [6:0]            cnt_d, cnt_q;
  logic                  done_d, done_q;

  logic [6:0]  need;
  logic [17:0] tol2;
  logic [16:0] d_hi_short, d_hi_long, d_lo_short, d_lo_long, d_lo_long2;
  logic        zero_ok, one_ok;
  logic [6:0]  cnt_inc;

  // Clamp the bit goal to 1..DATA_WIDTH
  always_comb begin
    if (cfg_i.bits_needed == 7'd0) begin
      need = 7'd1;
    end else if (cfg_i.bits_needed > DwCnt) begin
      need = DwCnt;
    end else begin
      need = cfg_i.bits_needed;
    end
  end

  // Pair classification against the nominal timings
  assign tol2       = {tol_i, 1'b0};
  assign d_hi_short = abs_diff({1'b0, held_q}, {1'b0, cfg_i.short_time});
  assign d_hi_long  = abs_diff({1'b0, held_q}, {1'b0, cfg_i.long_time});
  assign d_lo_short = abs_diff({1'b0, pulse_i.duration}, {1'b0, cfg_i.short_time});
  assign d_lo_long  = abs_diff({1'b0, pulse_i.duration}, {1'b0, cfg_i.long_time});
  assign d_lo_long2 = abs_diff({1'b0, pulse_i.duration}, {cfg_i.long_time, 1'b0});

  always_comb begin
    if (cfg_i.ppm_sel) begin
      zero_ok = ({1'b0, d_hi_short} < tol2) && (d_lo_long < tol_i);
      one_ok  = ({1'b0, d_hi_short} < tol2) && !(d_lo_long < tol_i) &&
                ({1'b0, d_lo_long2} < tol2);
    end else begin
      zero_ok = (d_hi_short < tol_i) && (d_lo_long < tol_i);
      one_ok  = !zero_ok && (d_hi_long < tol_i) && (d_lo_short < tol_i);
    end
  end

  // Next state and result
  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    held_d      = held_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    done_d      = done_q;
    cnt_inc     = (cnt_q < DwCnt) ? cnt_q + 7'd1 : cnt_q;
    res_valid_o = 1'b0;
    res_found_o = 1'b0;
    if (fire_i) begin
      // a new capture clears the decoder before the pulse is handled
      if (pulse_i.capture_start) begin
        pos_d   = '0;
        phase_d = 1'b0;
        held_d  = '0;
        shift_d = '0;
        cnt_d   = '0;
        done_d  = 1'b0;
        cnt_inc = 7'd1;
      end
      if (!done_d) begin
        if (pos_d < cfg_i.preamble) begin
          pos_d = pos_d + 8'd1;
        end else if (!phase_d) begin
          held_d  = pulse_i.duration;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (!zero_ok && !one_ok) begin
            res_valid_o = 1'b1;
            done_d      = 1'b1;
          end else begin
            shift_d = {shift_d[DATA_WIDTH-2:0], one_ok};
            cnt_d   = cnt_inc;
            if (cnt_d >= need) begin
              res_valid_o = 1'b1;
              res_found_o = 1'b1;
              done_d      = 1'b1;
            end
          end
        end
        // end of capture without a decision reports failure
        if (!res_valid_o && pulse_i.capture_end) begin
          res_valid_o = 1'b1;
          done_d      = 1'b1;
        end
      end
    end
  end

  assign res_bits_o  = shift_d;
  assign res_total_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= 1'b0;
      held_q  <= '0;
      shift_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      held_q  <= held_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

endmodule
